// File: hdl/nibble_varint_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// nibble_varint_encoder_core_defines.svh
// Assertion macros used by the checker file of the nibble varint encoder.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_VARINT_ENCODER_CORE_DEFINES_SVH
`define NIBBLE_VARINT_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define NVE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("nve check failed");

// Next-cycle implication, disabled while reset is asserted
`define NVE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("nve check failed");

`endif

// File: hdl/nve_pkg.sv
// ----------------------------------------------------------------------------
// nve_pkg
// Types and constants of the nibble varint encoder.
// ----------------------------------------------------------------------------
package nve_pkg;

  localparam int unsigned ValueW = 31;
  localparam int unsigned NibW   = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxBytes = 5;
  localparam int unsigned BufW   = MaxBytes * ByteW;
  localparam int unsigned CntW   = 3;

  // Upper bounds of the code length classes
  localparam logic [ValueW-1:0] Lim1N = 31'h6;
  localparam logic [ValueW-1:0] Lim2N = 31'h3f;
  localparam logic [ValueW-1:0] Lim3N = 31'h1ff;
  localparam logic [ValueW-1:0] Lim4N = 31'hfff;
  localparam logic [ValueW-1:0] Lim5N = 31'h7fff;
  localparam logic [ValueW-1:0] Lim6N = 31'h3ffff;
  localparam logic [ValueW-1:0] Lim7N = 31'h1fffff;
  localparam logic [ValueW-1:0] Lim8N = 31'hffffff;

  // Input action codes
  localparam logic ActEncode = 1'b0;
  localparam logic ActFlush  = 1'b1;

  // Encoded bytes of one item and the half byte it leaves behind
  typedef struct packed {
    logic [BufW-1:0] bytes;
    logic [CntW-1:0] cnt;
    logic            half_vld;
    logic [NibW-1:0] half_nib;
  } nve_enc_t;

endpackage

// File: hdl/nve_if.sv
// ----------------------------------------------------------------------------
// nve_in_if / nve_out_if
// Valid/ready channels for input items and output bytes.
// ----------------------------------------------------------------------------
interface nve_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [nve_pkg::ValueW-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface nve_out_if;
  logic                      valid;
  logic                      ready;
  logic [nve_pkg::ByteW-1:0] out_byte;
  logic                      last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: hdl/nve_encode.sv
// ----------------------------------------------------------------------------
// nve_encode
// Builds the nibble code of one item, merges the held nibble and packs bytes.
// ----------------------------------------------------------------------------
module nve_encode (
  input  logic                        action_i,
  input  logic [nve_pkg::ValueW-1:0]  value_i,
  input  logic                        half_vld_i,
  input  logic [nve_pkg::NibW-1:0]    half_nib_i,
  output nve_pkg::nve_enc_t           enc_o
);

  logic [39:0] code;
  logic [3:0]  len;
  logic [43:0] seq;
  logic [43:0] sh;
  logic [3:0]  tot;

  always_comb begin
    code = '0;
    len  = '0;
    // pick the code class, left-align the code nibbles
    priority if (value_i <= nve_pkg::Lim1N) begin
      code = {value_i[3:0], 36'd0};
      len  = 4'd1;
    end else if (value_i <= nve_pkg::Lim2N) begin
      code = {2'b10, value_i[5:0], 32'd0};
      len  = 4'd2;
    end else if (value_i <= nve_pkg::Lim3N) begin
      code = {3'b110, value_i[8:0], 28'd0};
      len  = 4'd3;
    end else if (value_i <= nve_pkg::Lim4N) begin
      code = {4'he, value_i[11:0], 24'd0};
      len  = 4'd4;
    end else if (value_i <= nve_pkg::Lim5N) begin
      code = {4'hf, value_i[15:0], 20'd0};
      len  = 4'd5;
    end else if (value_i <= nve_pkg::Lim6N) begin
      code = {4'hf, 2'b10, value_i[17:0], 16'd0};
      len  = 4'd6;
    end else if (value_i <= nve_pkg::Lim7N) begin
      code = {4'hf, 3'b110, value_i[20:0], 12'd0};
      len  = 4'd7;
    end else if (value_i <= nve_pkg::Lim8N) begin
      code = {8'hfe, value_i[23:0], 8'd0};
      len  = 4'd8;
    end else begin
      code = {8'h74, 1'b0, value_i};
      len  = 4'd10;
    end

    // prepend the held nibble, if any
    seq = half_vld_i ? {half_nib_i, code} : {code, 4'd0};
    tot = len + {3'd0, half_vld_i};
    sh  = seq << {tot - 4'd1, 2'b00};

    enc_o.bytes    = seq[43:4];
    enc_o.cnt      = tot[3:1];
    enc_o.half_vld = tot[0];
    enc_o.half_nib = tot[0] ? sh[43:40] : 4'd0;

    // flush: emit the held nibble with a zero low half
    if (action_i == nve_pkg::ActFlush) begin
      enc_o.bytes    = {half_nib_i, 36'd0};
      enc_o.cnt      = {2'd0, half_vld_i};
      enc_o.half_vld = 1'b0;
      enc_o.half_nib = 4'd0;
    end
  end

endmodule

// File: hdl/nve_byte_buf.sv
// ----------------------------------------------------------------------------
// nve_byte_buf
// Result register: holds the bytes of one item and hands them out one a word.
// ----------------------------------------------------------------------------
module nve_byte_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  nve_pkg::nve_enc_t          enc_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [nve_pkg::ByteW-1:0]  out_byte_o,
  output logic                       out_last_o,
  output logic                       free_o
);

  logic [nve_pkg::BufW-1:0] buf_q, buf_d;
  logic [nve_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [nve_pkg::CntW-1:0] idx_q, idx_d;
  logic [nve_pkg::BufW-1:0] sel;
  logic                     fire;

  // present the current byte
  assign sel         = buf_q << {idx_q, 3'b000};
  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = sel[nve_pkg::BufW-1 -: nve_pkg::ByteW];
  assign out_last_o  = (idx_q == cnt_q - 3'd1);
  assign fire        = out_valid_o && out_ready_i;
  assign free_o      = (cnt_q == '0) || (fire && out_last_o);

  // load a new item or advance through the held one
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      buf_d = enc_i.bytes;
      cnt_d = enc_i.cnt;
      idx_d = '0;
    end else if (fire) begin
      if (out_last_o) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// File: hdl/nibble_varint_encoder_core.sv
// An item passes the input register and then the result register before its
// first byte shows. Throughput: one output word per cycle while the output is
// ready; an item holds the result register until its last byte is taken.
// The next item is taken while the last byte of the previous one goes out.
// Reset (rst_ni low, asynchronous) empties both registers and drops the held
// nibble.
// ----------------------------------------------------------------------------
// nibble_varint_encoder_core
// Prefix-coded nibble varint encoder packing codes into a byte stream.
// ----------------------------------------------------------------------------
module nibble_varint_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  nve_in_if.sink     in_i,
  nve_out_if.source  out_o
);

  logic                       in_vld_q, in_vld_d;
  logic                       action_q;
  logic [nve_pkg::ValueW-1:0] value_q;
  logic                       half_vld_q, half_vld_d;
  logic [nve_pkg::NibW-1:0]   half_nib_q, half_nib_d;
  logic                       in_fire;
  logic                       load;
  logic                       buf_free;
  nve_pkg::nve_enc_t          enc;

  // move the input word on when the result register frees up
  assign load       = in_vld_q && buf_free;
  assign in_i.ready = !in_vld_q || load;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d   = in_vld_q;
    half_vld_d = half_vld_q;
    half_nib_d = half_nib_q;
    if (load) begin
      in_vld_d   = 1'b0;
      half_vld_d = enc.half_vld;
      half_nib_d = enc.half_nib;
    end
    if (in_fire) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      half_vld_q <= 1'b0;
      half_nib_q <= '0;
    end else begin
      in_vld_q   <= in_vld_d;
      half_vld_q <= half_vld_d;
      half_nib_q <= half_nib_d;
    end
  end

  // capture the input payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= in_i.action;
      value_q  <= in_i.value;
    end
  end

  nve_encode u_encode (
    .action_i   (action_q),
    .value_i    (value_q),
    .half_vld_i (half_vld_q),
    .half_nib_i (half_nib_q),
    .enc_o      (enc)
  );

  nve_byte_buf u_byte_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .enc_i       (enc),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last),
    .free_o      (buf_free)
  );

endmodule

// File: hdl/nve_checker.sv
// ----------------------------------------------------------------------------
// nve_checker
// Port-level checks of the nibble varint encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "nibble_varint_encoder_core_defines.svh"

module nve_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [nve_pkg::ByteW-1:0] out_byte_i,
  input logic                      out_last_i
);

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // hold a stalled output word
  `NVE_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `NVE_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_byte_i) && $stable(out_last_i))

  // bytes of one item leave without gaps
  `NVE_ASSERT_NEXT(a_burst_gapless, clk_i, rst_ni, out_fire && !out_last_i, out_valid_i)

  // a fresh burst starts after an item was taken and passed the input register
  `NVE_ASSERT_NOW(a_burst_origin, clk_i, rst_ni, $rose(out_valid_i), $past(in_fire, 2))

endmodule

bind nibble_varint_encoder_core nve_checker u_nve_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last)
);
